[hw/rtl/olist_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olist_pkg: shared types for the ordered list engine
// Operation codes, result status codes, compare unit ops and sequencer states.
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [3:0] {
    ACT_APPEND   = 4'd0,
    ACT_INSERT   = 4'd1,
    ACT_REMOVE   = 4'd2,
    ACT_READ     = 4'd3,
    ACT_CONTAINS = 4'd4,
    ACT_DEDUP    = 4'd5,
    ACT_DROPNEG  = 4'd6,
    ACT_MIN      = 4'd7,
    ACT_MAX      = 4'd8
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMP_EQ  = 2'd0,
    CMP_LT  = 2'd1,
    CMP_GT  = 2'd2,
    CMP_NEG = 2'd3
  } cmp_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_DEC  = 3'd1,
    S_SCAN = 3'd2,
    S_DRD  = 3'd3,
    S_DLD  = 3'd4,
    S_DPUT = 3'd5,
    S_FIN  = 3'd6
  } state_e;

endpackage
`default_nettype wire

[hw/rtl/olist_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olist_mem: entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module olist_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/olist_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olist_alu: shared compare unit
// Equality, signed less/greater than and sign test on one stored word.
// ----------------------------------------------------------------------------
module olist_alu
  import olist_pkg::*;
(
  input  wire cmp_e                       op_i,
  input  wire logic signed [DATA_W-1:0]   a_i,
  input  wire logic signed [DATA_W-1:0]   b_i,
  output logic                            hit_o
);

  always_comb begin
    unique case (op_i)
      CMP_EQ:  hit_o = (a_i == b_i);
      CMP_LT:  hit_o = (a_i < b_i);
      CMP_GT:  hit_o = (a_i > b_i);
      CMP_NEG: hit_o = a_i[DATA_W-1];
      default: hit_o = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/ordered_list_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_engine: fixed-capacity ordered list of signed 32-bit values
// Sequencer driving one entry memory and one shared compare unit.
// ----------------------------------------------------------------------------
// One word in gives one word out. The list lives in a single-port-read memory,
// so entries are visited one at a time: append and refused operations visit
// none, and insert, remove, contains, drop negatives, min and max scan the
// entries that they cover. Dedup runs a scan of the later entries for each
// entry. The input is stalled until the result is loaded into the output
// register; a waiting result does not block the next word from being taken.
module ordered_list_engine
  import olist_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [3:0]                          action_i,
  input  wire logic [$clog2(CAPACITY)-1:0]         position_i,
  input  wire logic signed [DATA_W-1:0]            operand_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [DATA_W-1:0]                 result_value_o,
  output logic                                     found_o,
  output logic [$clog2(CAPACITY+1)-1:0]            entry_count_o,
  output logic [1:0]                               status_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_e                    state_q, state_d;
  logic [CW-1:0]             count_q, count_d;
  logic [CW-1:0]             idx_q, idx_d;
  logic [CW-1:0]             lim_q, lim_d;
  logic [CW-1:0]             wk_q, wk_d;
  logic [CW-1:0]             oi_q, oi_d;
  logic [3:0]                act_q, act_d;
  logic [AW-1:0]             pos_q, pos_d;
  logic signed [DATA_W-1:0]  opv_q, opv_d;
  logic signed [DATA_W-1:0]  acc_q, acc_d;
  logic                      flag_q, flag_d;
  logic                      pv_q, pv_d;
  logic [AW-1:0]             ptag_q, ptag_d;
  status_e                   st_q, st_d;

  logic                      out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0]  res_q, res_d;
  logic                      found_q, found_d;
  logic [CW-1:0]             cnt_out_q, cnt_out_d;
  status_e                   stat_out_q, stat_out_d;

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic signed [DATA_W-1:0]  mem_wdata;
  logic                      mem_re;
  logic [AW-1:0]             mem_raddr;
  logic signed [DATA_W-1:0]  mem_rdata;

  cmp_e                      cmp_op;
  logic signed [DATA_W-1:0]  cmp_b;
  logic                      cmp_hit;

  logic [CW-1:0]             pos_ext;
  logic                      issue;
  logic                      down;

  olist_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  olist_alu u_alu (
    .op_i  (cmp_op),
    .a_i   (mem_rdata),
    .b_i   (cmp_b),
    .hit_o (cmp_hit)
  );

  assign pos_ext = CW'(pos_q);
  assign issue   = (state_q == S_SCAN) && (idx_q != lim_q);
  assign down    = (act_q == ACT_INSERT);

  always_comb begin
    unique case (act_q)
      ACT_MIN:     cmp_op = CMP_LT;
      ACT_MAX:     cmp_op = CMP_GT;
      ACT_DROPNEG: cmp_op = CMP_NEG;
      default:     cmp_op = CMP_EQ;
    endcase
    cmp_b = (act_q == ACT_CONTAINS) ? opv_q : acc_q;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    lim_d       = lim_q;
    wk_d        = wk_q;
    oi_d        = oi_q;
    act_d       = act_q;
    pos_d       = pos_q;
    opv_d       = opv_q;
    acc_d       = acc_q;
    flag_d      = flag_q;
    pv_d        = 1'b0;
    ptag_d      = ptag_q;
    st_d        = st_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    found_d     = found_q;
    cnt_out_d   = cnt_out_q;
    stat_out_d  = stat_out_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = action_i;
          pos_d   = position_i;
          opv_d   = operand_value_i;
          state_d = S_DEC;
        end
      end

      S_DEC: begin
        st_d    = ST_OK;
        flag_d  = 1'b0;
        wk_d    = '0;
        acc_d   = '0;
        state_d = S_FIN;
        case (act_q)
          ACT_APPEND: begin
            if (count_q == CAP_C) begin
              st_d = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = AW'(count_q);
              mem_wdata = opv_q;
              count_d   = count_q + 1'b1;
            end
          end
          ACT_INSERT: begin
            if (count_q == CAP_C) begin
              st_d = ST_FULL;
            end else if (pos_ext > count_q) begin
              st_d = ST_RANGE;
            end else begin
              idx_d   = count_q;
              lim_d   = pos_ext;
              state_d = S_SCAN;
            end
          end
          ACT_REMOVE: begin
            if (pos_ext >= count_q) begin
              st_d = ST_RANGE;
            end else begin
              idx_d   = pos_ext + 1'b1;
              lim_d   = count_q;
              state_d = S_SCAN;
            end
          end
          ACT_READ: begin
            if (pos_ext >= count_q) begin
              st_d = ST_RANGE;
            end else begin
              idx_d   = pos_ext;
              lim_d   = pos_ext + 1'b1;
              state_d = S_SCAN;
            end
          end
          ACT_CONTAINS, ACT_DROPNEG: begin
            idx_d   = '0;
            lim_d   = count_q;
            state_d = S_SCAN;
          end
          ACT_MIN, ACT_MAX: begin
            if (count_q == '0) begin
              st_d = ST_EMPTY;
            end else begin
              idx_d   = '0;
              lim_d   = count_q;
              state_d = S_SCAN;
            end
          end
          ACT_DEDUP: begin
            oi_d    = '0;
            state_d = S_DRD;
          end
          default: ;
        endcase
      end

      S_SCAN: begin
        if (issue) begin
          mem_re    = 1'b1;
          mem_raddr = down ? AW'(idx_q - 1'b1) : AW'(idx_q);
          idx_d     = down ? (idx_q - 1'b1) : (idx_q + 1'b1);
          ptag_d    = mem_raddr;
          pv_d      = 1'b1;
        end
        // returning word from the previous read
        if (pv_q) begin
          case (act_q)
            ACT_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = ptag_q + 1'b1;
            end
            ACT_REMOVE: begin
              mem_we    = 1'b1;
              mem_waddr = ptag_q - 1'b1;
            end
            ACT_READ: acc_d = mem_rdata;
            ACT_CONTAINS, ACT_DEDUP: begin
              if (cmp_hit) begin
                flag_d = 1'b1;
              end
            end
            ACT_DROPNEG: begin
              if (!cmp_hit) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(wk_q);
                wk_d      = wk_q + 1'b1;
              end
            end
            ACT_MIN, ACT_MAX: begin
              if (!flag_q || cmp_hit) begin
                acc_d = mem_rdata;
              end
              flag_d = 1'b1;
            end
            default: ;
          endcase
        end
        if (!issue && !pv_q) begin
          state_d = S_FIN;
          case (act_q)
            ACT_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = pos_q;
              mem_wdata = opv_q;
              count_d   = count_q + 1'b1;
            end
            ACT_REMOVE:  count_d = count_q - 1'b1;
            ACT_DROPNEG: count_d = wk_q;
            ACT_DEDUP:   state_d = S_DPUT;
            default: ;
          endcase
        end
      end

      S_DRD: begin
        if (oi_q == count_q) begin
          count_d = wk_q;
          state_d = S_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(oi_q);
          state_d   = S_DLD;
        end
      end

      S_DLD: begin
        acc_d   = mem_rdata;
        flag_d  = 1'b0;
        idx_d   = oi_q + 1'b1;
        lim_d   = count_q;
        state_d = S_SCAN;
      end

      S_DPUT: begin
        // keep this entry only when no equal entry follows it
        if (!flag_q) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(wk_q);
          mem_wdata = acc_q;
          wk_d      = wk_q + 1'b1;
        end
        oi_d    = oi_q + 1'b1;
        state_d = S_DRD;
      end

      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          res_d       = ((act_q == ACT_READ || act_q == ACT_MIN || act_q == ACT_MAX)
                         && st_q == ST_OK) ? acc_q : '0;
          found_d     = (act_q == ACT_CONTAINS) && flag_q;
          cnt_out_d   = count_q;
          stat_out_d  = st_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pv_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      pv_q        <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    lim_q      <= lim_d;
    wk_q       <= wk_d;
    oi_q       <= oi_d;
    act_q      <= act_d;
    pos_q      <= pos_d;
    opv_q      <= opv_d;
    acc_q      <= acc_d;
    flag_q     <= flag_d;
    ptag_q     <= ptag_d;
    st_q       <= st_d;
    res_q      <= res_d;
    found_q    <= found_d;
    cnt_out_q  <= cnt_out_d;
    stat_out_q <= stat_out_d;
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign found_o        = found_q;
  assign entry_count_o  = cnt_out_q;
  assign status_o       = stat_out_q;

`ifndef NO_ASSERTIONS
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("entry count beyond capacity");

  a_pipe_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> state_q == S_SCAN)
    else $error("read word pending outside a scan");

  a_accept_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == S_DEC)
    else $error("accepted word not decoded");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_EMPTY) |-> result_value_o == '0)
    else $error("empty status with nonzero value");
`endif

endmodule
`default_nettype wire

[tb/sv/ordered_list_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_checker: result predictor and comparator for the list engine
// Watches both word channels of the engine. Each accepted input word is applied
// to a shadow copy of the list. The predicted result word is queued, and each
// accepted output word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ordered_list_checker
  import olist_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  input  wire logic                             in_stall_i,
  input  wire logic [3:0]                       action_i,
  input  wire logic [$clog2(CAPACITY)-1:0]      position_i,
  input  wire logic signed [DATA_W-1:0]         operand_value_i,
  input  wire logic                             out_valid_i,
  input  wire logic                             out_stall_i,
  input  wire logic signed [DATA_W-1:0]         result_value_i,
  input  wire logic                             found_i,
  input  wire logic [$clog2(CAPACITY+1)-1:0]    entry_count_i,
  input  wire logic [1:0]                       status_i,
  output int unsigned                           error_count_o,
  output int unsigned                           pending_o
);

  typedef logic [$clog2(CAPACITY+1)-1:0] count_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     found;
    count_t                   count;
    status_e                  status;
  } list_result_t;

  logic signed [DATA_W-1:0] shadow_list [CAPACITY];
  int unsigned              shadow_count;
  list_result_t             expected_words [$];
  int unsigned              error_count;

  assign error_count_o = error_count;
  assign pending_o     = expected_words.size();

  function automatic list_result_t apply_word(input logic [3:0] act, input int unsigned pos,
                                              input logic signed [DATA_W-1:0] val);
    list_result_t r;
    int unsigned  n;
    int unsigned  k;
    bit           later;
    r.value  = '0;
    r.found  = 1'b0;
    r.status = ST_OK;
    n = shadow_count;
    case (act)
      ACT_APPEND: begin
        if (n >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_list[n] = val;
          n++;
        end
      end
      ACT_INSERT: begin
        if (n >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (pos > n) begin
          r.status = ST_RANGE;
        end else begin
          for (int unsigned i = n; i > pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = val;
          n++;
        end
      end
      ACT_REMOVE: begin
        if (pos >= n) begin
          r.status = ST_RANGE;
        end else begin
          for (int unsigned i = pos; i + 1 < n; i++) shadow_list[i] = shadow_list[i+1];
          n--;
        end
      end
      ACT_READ: begin
        if (pos >= n) r.status = ST_RANGE;
        else r.value = shadow_list[pos];
      end
      ACT_CONTAINS: begin
        for (int unsigned i = 0; i < n; i++)
          if (shadow_list[i] == val) r.found = 1'b1;
      end
      ACT_DEDUP: begin
        // keep only the last copy of each value, in place
        k = 0;
        for (int unsigned i = 0; i < n; i++) begin
          later = 1'b0;
          for (int unsigned j = i + 1; j < n; j++)
            if (shadow_list[j] == shadow_list[i]) later = 1'b1;
          if (!later) begin
            shadow_list[k] = shadow_list[i];
            k++;
          end
        end
        n = k;
      end
      ACT_DROPNEG: begin
        k = 0;
        for (int unsigned i = 0; i < n; i++) begin
          if (!shadow_list[i][DATA_W-1]) begin
            shadow_list[k] = shadow_list[i];
            k++;
          end
        end
        n = k;
      end
      ACT_MIN, ACT_MAX: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = shadow_list[0];
          for (int unsigned i = 1; i < n; i++) begin
            if ((act == ACT_MIN && shadow_list[i] < r.value) ||
                (act == ACT_MAX && shadow_list[i] > r.value))
              r.value = shadow_list[i];
          end
        end
      end
      default: begin
      end
    endcase
    shadow_count = n;
    r.count = count_t'(n);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      shadow_count = 0;
      expected_words.delete();
      error_count = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word: value %0d found %0b count %0d status %0d",
                   $time, result_value_i, found_i, entry_count_i, status_i);
          error_count++;
        end else begin
          want = expected_words.pop_front();
          if (result_value_i !== want.value) begin
            $display("%0t: result_value expected %0d got %0d", $time, want.value,
                     result_value_i);
            error_count++;
          end
          if (found_i !== want.found) begin
            $display("%0t: found expected %0b got %0b", $time, want.found, found_i);
            error_count++;
          end
          if (entry_count_i !== want.count) begin
            $display("%0t: entry_count expected %0d got %0d", $time, want.count,
                     entry_count_i);
            error_count++;
          end
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, status_i);
            error_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_words.push_back(apply_word(action_i, position_i, operand_value_i));
    end
  end

endmodule

[tb/sv/ordered_list_engine_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine_test: stimulus and verdict for the ordered list engine
// A directed pass over empty, partial and edge cases is followed by random
// words that alternate between growing and shrinking the list. Both channels
// idle at random; a separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module ordered_list_engine_test;
  import olist_pkg::*;

  localparam int unsigned CAPACITY      = 16;
  localparam int unsigned RANDOM_WORDS  = 1750;
  localparam int unsigned IDLE_LIMIT    = 5000;
  localparam int unsigned DRAIN_CYCLES  = 300;
  localparam logic [3:0]  ACT_UNUSED_LO = 4'd9;
  localparam logic [3:0]  ACT_UNUSED_HI = 4'd15;

  logic                                  clk_i = 1'b0;
  logic                                  rst_ni = 1'b0;
  logic                                  in_valid_i = 1'b0;
  logic                                  in_stall_o;
  logic [3:0]                            action_i = ACT_APPEND;
  logic [$clog2(CAPACITY)-1:0]           position_i = '0;
  logic signed [DATA_W-1:0]              operand_value_i = '0;
  logic                                  out_valid_o;
  logic                                  out_stall_i = 1'b0;
  logic signed [DATA_W-1:0]              result_value_o;
  logic                                  found_o;
  logic [$clog2(CAPACITY+1)-1:0]         entry_count_o;
  logic [1:0]                            status_o;

  int unsigned error_count;
  int unsigned pending_results;
  int unsigned idle_cycles = 0;

  ordered_list_engine #(.CAPACITY(CAPACITY)) dut (.*);

  ordered_list_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .action_i        (action_i),
    .position_i      (position_i),
    .operand_value_i (operand_value_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_value_i  (result_value_o),
    .found_i         (found_o),
    .entry_count_i   (entry_count_o),
    .status_i        (status_o),
    .error_count_o   (error_count),
    .pending_o       (pending_results)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("ordered_list_engine_test: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return $signed(DATA_W'($urandom_range(0, 7))) - 4;
    if (roll < 60) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [3:0] pick_action(input bit growing);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (growing) begin
      if (roll < 40) return ACT_APPEND;
      if (roll < 65) return ACT_INSERT;
      if (roll < 72) return ACT_REMOVE;
      if (roll < 80) return ACT_READ;
      if (roll < 86) return ACT_CONTAINS;
      if (roll < 89) return ACT_DEDUP;
      if (roll < 91) return ACT_DROPNEG;
      if (roll < 94) return ACT_MIN;
      if (roll < 97) return ACT_MAX;
    end else begin
      if (roll < 15) return ACT_APPEND;
      if (roll < 25) return ACT_INSERT;
      if (roll < 55) return ACT_REMOVE;
      if (roll < 67) return ACT_READ;
      if (roll < 75) return ACT_CONTAINS;
      if (roll < 82) return ACT_DEDUP;
      if (roll < 87) return ACT_DROPNEG;
      if (roll < 91) return ACT_MIN;
      if (roll < 95) return ACT_MAX;
    end
    return 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic [3:0] act, input logic [3:0] pos,
                           input logic signed [DATA_W-1:0] val, input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    position_i      <= pos;
    operand_value_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // result side back-pressure, with calm windows
  initial begin
    int unsigned stall_left;
    int unsigned rx_cycles;
    stall_left = 0;
    rx_cycles  = 0;
    forever begin
      @(negedge clk_i);
      rx_cycles++;
      if (stall_left == 0 && ((rx_cycles / 256) % 4) != 1 && $urandom_range(0, 4) == 0)
        stall_left = pick_gap();
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin
    bit          growing;
    bit          calm;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list
    send_word(ACT_READ,     4'd0,  32'sd0,         pick_gap());
    send_word(ACT_REMOVE,   4'd15, 32'sd0,         pick_gap());
    send_word(ACT_MIN,      4'd0,  32'sd0,         pick_gap());
    send_word(ACT_MAX,      4'd0,  32'sd0,         pick_gap());
    send_word(ACT_CONTAINS, 4'd0,  32'sd0,         pick_gap());
    send_word(ACT_DEDUP,    4'd0,  32'sd0,         pick_gap());
    send_word(ACT_DROPNEG,  4'd0,  32'sd0,         pick_gap());
    send_word(ACT_INSERT,   4'd1,  32'sd7,         pick_gap());
    // build a short list with extremes and duplicates, then query and shrink it
    send_word(ACT_INSERT,   4'd0,  32'sh7fff_ffff, pick_gap());
    send_word(ACT_APPEND,   4'd0,  32'sh8000_0000, pick_gap());
    send_word(ACT_APPEND,   4'd0,  -32'sd1,        pick_gap());
    send_word(ACT_INSERT,   4'd3,  32'sd5,         pick_gap());
    send_word(ACT_APPEND,   4'd15, 32'sd5,         pick_gap());
    send_word(ACT_APPEND,   4'd0,  -32'sd1,        pick_gap());
    send_word(ACT_CONTAINS, 4'd0,  -32'sd1,        pick_gap());
    send_word(ACT_CONTAINS, 4'd0,  32'sd1234,      pick_gap());
    send_word(ACT_READ,     4'd15, 32'sd0,         pick_gap());
    send_word(ACT_READ,     4'd1,  32'sd0,         pick_gap());
    send_word(ACT_MIN,      4'd0,  32'sd0,         pick_gap());
    send_word(ACT_MAX,      4'd0,  32'sd0,         pick_gap());
    send_word(ACT_DEDUP,    4'd0,  32'sd0,         pick_gap());
    send_word(ACT_DROPNEG,  4'd0,  32'sd0,         pick_gap());
    send_word(ACT_REMOVE,   4'd0,  32'sd0,         pick_gap());
    send_word(ACT_UNUSED_LO, 4'd0, '1,             pick_gap());
    send_word(ACT_UNUSED_HI, 4'd0, 32'sd0,         pick_gap());
    send_word(ACT_REMOVE,   4'd0,  32'sd0,         pick_gap());

    for (int unsigned idx = 0; idx < RANDOM_WORDS; idx++) begin
      growing = ((idx / 40) % 2) == 0;
      calm    = ((idx / 100) % 3) == 2;
      // let the engine drain completely before continuing
      if (idx == RANDOM_WORDS / 2 || $urandom_range(0, 149) == 0) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        wait (pending_results == 0);
        @(negedge clk_i);
      end
      send_word(pick_action(growing),
                ($urandom_range(0, 9) < 4) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, 7)),
                pick_value(), calm ? 0 : pick_gap());
    end

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    wait (pending_results == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_results == 0)
      $display("ordered_list_engine_test: clean");
    else
      $display("ordered_list_engine_test: errors");
    $finish;
  end

endmodule
